### rtl/its_pkg.sv
// ----------------------------------------------------------------------------
// its_pkg
// Shared types and constants for the interval table binary search block:
// beat structs, sequencer states, op codes and register indexes.
// ----------------------------------------------------------------------------
package its_pkg;

	// fixed field widths
	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int ADDR_W  = 64;
	localparam int ENTRY_W = 32;

	// defaults for the top level parameters
	localparam int TABLE_DEPTH_DEF  = 1024;
	localparam int OFFSET_WIDTH_DEF = 32;

	// input op codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// configuration register indexes
	localparam int  CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE  = 1'b1;
	localparam int  CFG_DATA_W = 64;

	// input beat
	typedef struct packed {
		logic               op;
		logic [INDEX_W-1:0] entry_index;
		logic [ENTRY_W-1:0] entry_begin;
		logic [ENTRY_W-1:0] entry_end;
		logic [ADDR_W-1:0]  query_address;
	} in_beat_t;

	// output beat
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] function_start;
	} out_beat_t;

	// result of one probe of the compare unit
	typedef struct packed {
		logic               more;
		logic               hit;
		logic [COUNT_W-1:0] mid;
		logic [COUNT_W-1:0] lo_n;
		logic [COUNT_W-1:0] hi_n;
	} step_res_t;

	// search sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

### rtl/its_ram.sv
// ----------------------------------------------------------------------------
// its_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module its_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/its_step.sv
// ----------------------------------------------------------------------------
// its_step
// Shared probe unit: forms the midpoint of the current bounds and compares
// the probed range against the target to give the next bounds or a hit.
// ----------------------------------------------------------------------------
module its_step #(
	parameter int OFFSET_WIDTH = its_pkg::OFFSET_WIDTH_DEF
) (
	input  logic [its_pkg::COUNT_W-1:0] lo,
	input  logic [its_pkg::COUNT_W-1:0] hi,
	input  logic [OFFSET_WIDTH-1:0]     rd_begin,
	input  logic [OFFSET_WIDTH-1:0]     rd_end,
	input  logic [OFFSET_WIDTH-1:0]     target,
	output its_pkg::step_res_t          res
);

	logic [its_pkg::COUNT_W:0] sum;

	// midpoint of the bounds
	assign sum = {1'b0, lo} + {1'b0, hi};

	// compare and next bounds
	always_comb begin
		res.more = (lo < hi);
		res.mid  = sum[its_pkg::COUNT_W:1];
		res.hit  = 1'b0;
		res.lo_n = lo;
		res.hi_n = hi;
		priority if (rd_end <= target) begin
			res.lo_n = res.mid + its_pkg::COUNT_W'(1);
		end else if (rd_begin > target) begin
			res.hi_n = res.mid;
		end else begin
			res.hit = 1'b1;
		end
	end

endmodule

### rtl/interval_table_binary_search.sv
// ----------------------------------------------------------------------------
// interval_table_binary_search
// Sorted range table with a binary search lookup of query addresses.
// ----------------------------------------------------------------------------
// A write beat (op = 0) stores one begin/end pair. A query beat (op = 1)
// subtracts image_base, keeps the low OFFSET_WIDTH bits as the target, and
// halves the bounds [0, min(entry_count, TABLE_DEPTH)) until a range with
// begin <= target < end is found or the bounds meet. Every probe issues the
// table read and then compares the registered read data; the single read
// port of the table and its registered output set that order. The block
// takes no input beat while a query is in flight. A finished result sits in
// an output register, so a new beat is taken while it waits. Slots never
// written must not be probed; their contents are undefined.
// ----------------------------------------------------------------------------
module interval_table_binary_search #(
	parameter int TABLE_DEPTH  = its_pkg::TABLE_DEPTH_DEF,
	parameter int OFFSET_WIDTH = its_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  its_pkg::in_beat_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output its_pkg::out_beat_t               out_data,
	input  logic                             cfg_we,
	input  logic [its_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [its_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);

	its_pkg::state_t                state_q, state_d;
	logic [its_pkg::COUNT_W-1:0]    entry_count_q;
	logic [its_pkg::ADDR_W-1:0]     image_base_q;
	logic [its_pkg::COUNT_W-1:0]    lo_q, hi_q;
	logic [its_pkg::COUNT_W-1:0]    hi_init;
	logic [OFFSET_WIDTH-1:0]        target_q;
	logic [OFFSET_WIDTH-1:0]        hit_begin_q;
	logic                           hit_q;
	logic [its_pkg::ADDR_W-1:0]     diff;
	logic                           in_acc;
	logic                           wr_en;
	logic                           rd_en;
	logic                           out_load;
	logic [OFFSET_WIDTH-1:0]        rd_begin, rd_end;
	its_pkg::step_res_t             step;
	logic                           out_valid_q;
	its_pkg::out_beat_t             out_q;

	assign in_acc = in_valid && in_ready;
	assign wr_en  = in_acc && (in_data.op == its_pkg::OP_WRITE)
		&& (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
	assign diff   = in_data.query_address - image_base_q;

	// search bound saturated to the table depth
	always_comb begin
		if (32'(entry_count_q) > 32'(TABLE_DEPTH)) begin
			hi_init = its_pkg::COUNT_W'(TABLE_DEPTH);
		end else begin
			hi_init = entry_count_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			image_base_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				its_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_data[its_pkg::COUNT_W-1:0];
				its_pkg::CFG_IMAGE_BASE:  image_base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// range tables
	its_ram #(
		.WIDTH(OFFSET_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_begin_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(in_data.entry_index)),
		.wdata (in_data.entry_begin[OFFSET_WIDTH-1:0]),
		.re    (rd_en),
		.raddr (AW'(step.mid)),
		.rdata (rd_begin)
	);

	its_ram #(
		.WIDTH(OFFSET_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_end_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(in_data.entry_index)),
		.wdata (in_data.entry_end[OFFSET_WIDTH-1:0]),
		.re    (rd_en),
		.raddr (AW'(step.mid)),
		.rdata (rd_end)
	);

	// shared probe unit
	its_step #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_step (
		.lo       (lo_q),
		.hi       (hi_q),
		.rd_begin (rd_begin),
		.rd_end   (rd_end),
		.target   (target_q),
		.res      (step)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= its_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and controls
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			its_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_data.op == its_pkg::OP_QUERY) begin
					state_d = its_pkg::ST_PROBE;
				end
			end
			its_pkg::ST_PROBE: begin
				if (step.more) begin
					rd_en   = 1'b1;
					state_d = its_pkg::ST_CMP;
				end else begin
					state_d = its_pkg::ST_DONE;
				end
			end
			its_pkg::ST_CMP: begin
				if (step.hit) begin
					state_d = its_pkg::ST_DONE;
				end else begin
					state_d = its_pkg::ST_PROBE;
				end
			end
			its_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = its_pkg::ST_IDLE;
				end
			end
			default: state_d = its_pkg::ST_IDLE;
		endcase
	end

	// search bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q  <= '0;
			hi_q  <= '0;
			hit_q <= 1'b0;
		end else if (in_acc && in_data.op == its_pkg::OP_QUERY) begin
			lo_q  <= '0;
			hi_q  <= hi_init;
			hit_q <= 1'b0;
		end else if (state_q == its_pkg::ST_CMP) begin
			lo_q  <= step.lo_n;
			hi_q  <= step.hi_n;
			hit_q <= step.hit;
		end
	end

	// target and hit payload
	always_ff @(posedge clk) begin
		if (in_acc && in_data.op == its_pkg::OP_QUERY) begin
			target_q <= diff[OFFSET_WIDTH-1:0];
		end
		if (state_q == its_pkg::ST_CMP && step.hit) begin
			hit_begin_q <= rd_begin;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.found <= hit_q;
			if (hit_q) begin
				out_q.function_start <= image_base_q
					+ its_pkg::ADDR_W'(hit_begin_q);
			end else begin
				out_q.function_start <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// bounds stay ordered while searching
	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == its_pkg::ST_PROBE || state_q == its_pkg::ST_CMP) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	// upper bound never passes the table depth
	a_bound_depth: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hi_q) <= 32'(TABLE_DEPTH))
		else $error("search bound beyond table depth");

	// a compare always follows a read issue
	a_cmp_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == its_pkg::ST_CMP |-> $past(state_q) == its_pkg::ST_PROBE)
		else $error("compare without a table read");

	// a miss carries a zero start
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.found) |-> (out_q.function_start == '0))
		else $error("miss with nonzero function_start");

	// an accepted query starts the search
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_data.op == its_pkg::OP_QUERY) |=> state_q == its_pkg::ST_PROBE)
		else $error("query did not start a search");

endmodule
